### rtl/hmt_pkg.sv
package hmt_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int GW_W            = 11;
	localparam int CFG_IDX_W       = 1;
	localparam int DIVN_W          = 49;
	localparam int DIVD_W          = 35;
	localparam int SQRT_STEPS      = 17;
	localparam int RECIP_100       = 5243;
	localparam int SAT_LIMIT       = 25600;

	// reciprocals of the blend spans, scaled by 2^28
	localparam logic [25:0] RECIP_SPAN5  = 26'd53687092;
	localparam logic [25:0] RECIP_SPAN10 = 26'd26843546;
	localparam logic [25:0] RECIP_SPAN30 = 26'd8947849;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH    = 1'b0,
		REG_COLOUR_SCHEME = 1'b1
	} cfg_reg_t;

	typedef logic signed [15:0] height_t;
	typedef logic [10:0]        coord_t;

	typedef struct packed {
		height_t a;
		height_t b;
		height_t c;
		height_t d;
		coord_t  x0;
		coord_t  x1;
		coord_t  z0;
		coord_t  z1;
		logic    diag;
	} quad_t;

	typedef struct packed {
		logic [0:2][6:0] steep;
		logic [0:2][6:0] flat;
		logic [6:0]      lo;
		logic [6:0]      span;
	} pal_t;

	localparam pal_t PAL_WATER    = '{'{7'd15, 7'd15, 7'd40}, '{7'd30, 7'd40, 7'd80}, 7'd70, 7'd30};
	localparam pal_t PAL_SNOWY    = '{'{7'd35, 7'd30, 7'd25}, '{7'd95, 7'd95, 7'd95}, 7'd90, 7'd5};
	localparam pal_t PAL_MOUNTAIN = '{'{7'd35, 7'd30, 7'd25}, '{7'd35, 7'd30, 7'd25}, 7'd80, 7'd10};
	localparam pal_t PAL_PLAINS   = '{'{7'd35, 7'd20, 7'd0},  '{7'd25, 7'd40, 7'd5},  7'd80, 7'd10};
	localparam pal_t PAL_SAND     = '{'{7'd80, 7'd80, 7'd70}, '{7'd80, 7'd80, 7'd70}, 7'd80, 7'd10};

	localparam logic signed [17:0] BAND_SNOW  = 18'sd8448;
	localparam logic signed [17:0] BAND_STONE = 18'sd3840;
	localparam logic signed [17:0] BAND_DIRT  = 18'sd1536;

	function automatic pal_t pal_sel(input logic water, input logic signed [17:0] s);
		pal_t p;
		if (water)
			p = PAL_WATER;
		else if (s > BAND_SNOW)
			p = PAL_SNOWY;
		else if (s > BAND_STONE)
			p = PAL_MOUNTAIN;
		else if (s > BAND_DIRT)
			p = PAL_PLAINS;
		else
			p = PAL_SAND;
		return p;
	endfunction

endpackage

### rtl/hmt_intf.sv
interface hmt_height_if;
	logic           valid;
	logic           ready;
	logic signed [15:0] height;
	modport source (output valid, output height, input ready);
	modport sink (input valid, input height, output ready);
endinterface

interface hmt_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] x_coord;
	logic signed [15:0] y_height;
	logic signed [10:0] z_coord;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               last_of_quad;
	modport source (output valid, output x_coord, output y_height, output z_coord,
		output red, output green, output blue, output last_of_quad, input ready);
	modport sink (input valid, input x_coord, input y_height, input z_coord,
		input red, input green, input blue, input last_of_quad, output ready);
endinterface

### rtl/hmt_front.sv
module hmt_front #(
	parameter int MAX_WIDTH = hmt_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hmt_pkg::GW_W-1:0]  grid_width,
	hmt_height_if.sink                in_ch,
	output hmt_pkg::quad_t            quad,
	output logic                      quad_valid,
	input  logic                      quad_ready
);
	import hmt_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	typedef enum logic [1:0] {F_IDLE, F_READ, F_PUSH, F_WEND} fstate_t;

	fstate_t       state_q;
	logic [CW-1:0] col_cnt_q, row_cnt_q, col_q, row_q, wm1_q;
	logic          toggle_q;
	height_t       h_q, left_q, a_q, b_q;
	height_t       row_mem [MAX_WIDTH];

	logic [31:0]   w_wide, w_clamp, org, x0w, x1w, z0w, z1w;
	logic [CW-1:0] wm1, col_c, row_c, mem_addr;
	logic          quad_hit, push_done, mem_we;
	height_t       mem_wdata;

	always_comb begin
		w_wide  = 32'(grid_width);
		w_clamp = (w_wide < 32'd2) ? 32'd2 :
			((w_wide > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_wide);
		wm1     = CW'(w_clamp - 32'd1);
		col_c   = (col_cnt_q > wm1) ? wm1 : col_cnt_q;
		row_c   = (row_cnt_q > wm1) ? wm1 : row_cnt_q;
		org     = 32'(wm1_q) >> 1;
		x0w     = 32'(col_q) - 32'd1 - org;
		x1w     = 32'(col_q) - org;
		z0w     = 32'(row_q) - 32'd1 - org;
		z1w     = 32'(row_q) - org;
		quad_hit  = (col_q != '0) && (row_q != '0);
		push_done = !quad_hit || quad_ready;
		mem_we    = ((state_q == F_PUSH) && push_done && (col_q != '0)) || (state_q == F_WEND);
		mem_addr  = (state_q == F_WEND) ? col_q : col_q - 1'b1;
		mem_wdata = (state_q == F_WEND) ? h_q : left_q;
	end

	assign in_ch.ready = (state_q == F_IDLE);
	assign quad_valid  = (state_q == F_PUSH) && quad_hit;
	assign quad = '{a: a_q, b: b_q, c: left_q, d: h_q,
		x0: x0w[10:0], x1: x1w[10:0], z0: z0w[10:0], z1: z1w[10:0], diag: ~toggle_q};

	always_ff @(posedge clk) begin
		if (state_q == F_READ) begin
			a_q <= row_mem[col_q - 1'b1];
			b_q <= row_mem[col_q];
		end
		if (mem_we)
			row_mem[mem_addr] <= mem_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			wm1_q     <= '0;
			toggle_q  <= 1'b0;
			h_q       <= '0;
			left_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						h_q     <= in_ch.height;
						col_q   <= col_c;
						row_q   <= row_c;
						wm1_q   <= wm1;
						state_q <= F_READ;
					end
				end
				F_READ: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_done) begin
						left_q <= h_q;
						if ((col_q >= wm1_q) && (row_q >= wm1_q))
							toggle_q <= 1'b0;
						else if (quad_hit)
							toggle_q <= ~toggle_q;
						if (col_q >= wm1_q) begin
							col_cnt_q <= '0;
							if (row_q >= wm1_q) begin
								row_cnt_q <= '0;
							end else begin
								row_cnt_q <= row_q + 1'b1;
							end
							state_q <= F_WEND;
						end else begin
							col_cnt_q <= col_q + 1'b1;
							row_cnt_q <= row_q;
							state_q   <= F_IDLE;
						end
					end
				end
				F_WEND: state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	a_quad_corner: assert property (@(posedge clk) disable iff (!arst_n)
		quad_valid |-> (quad.x1 == quad.x0 + 11'd1) && (quad.z1 == quad.z0 + 11'd1))
		else $error("quad corners not adjacent");

endmodule

### rtl/hmt_fifo.sv
module hmt_fifo #(
	parameter int DEPTH = hmt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hmt_pkg::quad_t push_data,
	output logic           full,
	input  logic           pop,
	output hmt_pkg::quad_t pop_data,
	output logic           empty
);
	import hmt_pkg::*;

	localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	quad_t          slot_q [DEPTH];
	logic [IW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0] count_q;

	assign full     = (count_q == CNW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> !empty))
		else $error("queue overflow or underflow");

endmodule

### rtl/hmt_div.sv
module hmt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hmt_pkg::DIVN_W-1:0]  dividend,
	input  logic [hmt_pkg::DIVD_W-1:0]  divisor,
	output logic                        busy,
	output logic                        done,
	output logic [hmt_pkg::DIVN_W-1:0]  quotient
);
	import hmt_pkg::*;

	localparam int CNW = $clog2(DIVN_W + 1);

	logic [DIVD_W-1:0] rem_q, dsr_q;
	logic [DIVN_W-1:0] quo_q;
	logic [CNW-1:0]    cnt_q;
	logic              busy_q, done_q;
	logic [DIVD_W:0]   rem_sh, diff;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVN_W-1]};
		diff   = rem_sh - {1'b0, dsr_q};
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsr_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dsr_q  <= divisor;
				quo_q  <= dividend;
				cnt_q  <= CNW'(DIVN_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_sh >= {1'b0, dsr_q}) begin
					rem_q <= diff[DIVD_W-1:0];
					quo_q <= {quo_q[DIVN_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DIVD_W-1:0];
					quo_q <= {quo_q[DIVN_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !done_q)
		else $error("divider restarted while busy");

endmodule

### rtl/hmt_back.sv
module hmt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           colour_scheme,
	input  hmt_pkg::quad_t quad,
	input  logic           quad_valid,
	output logic           quad_ready,
	hmt_vertex_if.source   out_ch
);
	import hmt_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE, B_SQ, B_D1S, B_D1W, B_SQRT, B_ADJ, B_ADJS,
		B_MIX, B_PROD, B_SCALE, B_EMIT
	} bstate_t;

	typedef enum logic [1:0] {CN_A, CN_B, CN_C, CN_D} corner_t;

	bstate_t           state_q;
	quad_t             quad_q;
	logic              tri_q;
	logic [32:0]       sq1_q, sq2_q;
	logic [33:0]       n_q, r_q, bit_q;
	logic [4:0]        sqc_q;
	logic [16:0]       f_q, adj_q;
	logic [24:0]       num_q;
	logic              num_pos_q;
	pal_t              pal_q;
	logic [2:0][22:0]  mix_q;
	logic [2:0][39:0]  prod_q;
	logic [2:0][7:0]   c1_q, c2_q;
	logic [2:0]        k_q;

	logic signed [16:0] d1, d2;
	logic signed [17:0] s;
	logic signed [33:0] sqp1, sqp2;
	logic [33:0]        trial;
	logic [24:0]        hundred_f, lo_term;
	logic               div_start, div_busy, div_done;
	logic [DIVN_W-1:0]  div_dividend, div_quot;
	logic [DIVD_W-1:0]  div_divisor;
	logic [25:0]        span_recip;
	logic [48:0]        adj_prod;
	logic [2:0][7:0]    scaled;
	corner_t            corner;
	logic [15:0]        t_val;
	logic [27:0]        recip;

	always_comb begin
		if (quad_q.diag) begin
			if (!tri_q) begin
				s  = 18'(quad_q.a) + 18'(quad_q.b) + 18'(quad_q.c);
				d1 = 17'(quad_q.a) - 17'(quad_q.b);
				d2 = 17'(quad_q.a) - 17'(quad_q.c);
			end else begin
				s  = 18'(quad_q.b) + 18'(quad_q.d) + 18'(quad_q.c);
				d1 = 17'(quad_q.c) - 17'(quad_q.d);
				d2 = 17'(quad_q.b) - 17'(quad_q.d);
			end
		end else begin
			if (!tri_q) begin
				s  = 18'(quad_q.a) + 18'(quad_q.d) + 18'(quad_q.c);
				d1 = 17'(quad_q.c) - 17'(quad_q.d);
				d2 = 17'(quad_q.a) - 17'(quad_q.c);
			end else begin
				s  = 18'(quad_q.b) + 18'(quad_q.d) + 18'(quad_q.a);
				d1 = 17'(quad_q.a) - 17'(quad_q.b);
				d2 = 17'(quad_q.b) - 17'(quad_q.d);
			end
		end
		sqp1      = d1 * d1;
		sqp2      = d2 * d2;
		trial     = r_q + bit_q;
		hundred_f = 25'(r_q[16:0]) * 25'd100;
		lo_term   = 25'(pal_q.lo) << 16;
		div_start    = (state_q == B_D1S);
		div_dividend = DIVN_W'(1) << 48;
		div_divisor  = DIVD_W'(34'h10000) + DIVD_W'(sq1_q) + DIVD_W'(sq2_q);
		case (pal_q.span)
			7'd5:    span_recip = RECIP_SPAN5;
			7'd30:   span_recip = RECIP_SPAN30;
			default: span_recip = RECIP_SPAN10;
		endcase
		adj_prod = 49'(num_q[22:0]) * 49'(span_recip);
		for (int i = 0; i < 3; i++) begin
			t_val     = prod_q[i][39:24];
			recip     = 28'(t_val[14:0]) * 28'(RECIP_100);
			scaled[i] = (t_val >= 16'(SAT_LIMIT)) ? 8'd255 : recip[26:19];
		end
	end

	hmt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		case (k_q)
			3'd0: corner = CN_A;
			3'd1: corner = quad_q.diag ? CN_B : CN_D;
			3'd2: corner = CN_C;
			3'd3: corner = CN_B;
			3'd4: corner = CN_D;
			3'd5: corner = quad_q.diag ? CN_C : CN_A;
			default: corner = CN_A;
		endcase
		case (corner)
			CN_A: begin
				out_ch.x_coord  = quad_q.x0;
				out_ch.y_height = quad_q.a;
				out_ch.z_coord  = quad_q.z0;
			end
			CN_B: begin
				out_ch.x_coord  = quad_q.x1;
				out_ch.y_height = quad_q.b;
				out_ch.z_coord  = quad_q.z0;
			end
			CN_C: begin
				out_ch.x_coord  = quad_q.x0;
				out_ch.y_height = quad_q.c;
				out_ch.z_coord  = quad_q.z1;
			end
			CN_D: begin
				out_ch.x_coord  = quad_q.x1;
				out_ch.y_height = quad_q.d;
				out_ch.z_coord  = quad_q.z1;
			end
			default: begin
				out_ch.x_coord  = quad_q.x0;
				out_ch.y_height = quad_q.a;
				out_ch.z_coord  = quad_q.z0;
			end
		endcase
		if (k_q < 3'd3) begin
			out_ch.red   = c1_q[0];
			out_ch.green = c1_q[1];
			out_ch.blue  = c1_q[2];
		end else begin
			out_ch.red   = c2_q[0];
			out_ch.green = c2_q[1];
			out_ch.blue  = c2_q[2];
		end
	end

	assign out_ch.valid        = (state_q == B_EMIT);
	assign out_ch.last_of_quad = (k_q == 3'd5);
	assign quad_ready          = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			quad_q    <= '0;
			tri_q     <= 1'b0;
			sq1_q     <= '0;
			sq2_q     <= '0;
			n_q       <= '0;
			r_q       <= '0;
			bit_q     <= '0;
			sqc_q     <= '0;
			f_q       <= '0;
			adj_q     <= '0;
			num_q     <= '0;
			num_pos_q <= 1'b0;
			pal_q     <= '0;
			mix_q     <= '0;
			prod_q    <= '0;
			c1_q      <= '0;
			c2_q      <= '0;
			k_q       <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (quad_valid) begin
						quad_q  <= quad;
						tri_q   <= 1'b0;
						state_q <= B_SQ;
					end
				end
				B_SQ: begin
					sq1_q   <= sqp1[32:0];
					sq2_q   <= sqp2[32:0];
					pal_q   <= pal_sel(colour_scheme, s);
					state_q <= B_D1S;
				end
				B_D1S: state_q <= B_D1W;
				B_D1W: begin
					if (div_done) begin
						n_q     <= div_quot[33:0];
						r_q     <= '0;
						bit_q   <= 34'h1 << 32;
						sqc_q   <= '0;
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					if (n_q >= trial) begin
						n_q <= n_q - trial;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					sqc_q <= sqc_q + 1'b1;
					if (sqc_q == 5'(SQRT_STEPS - 1))
						state_q <= B_ADJ;
				end
				B_ADJ: begin
					f_q       <= r_q[16:0];
					num_q     <= hundred_f - lo_term;
					num_pos_q <= hundred_f > lo_term;
					state_q   <= B_ADJS;
				end
				B_ADJS: begin
					if (num_pos_q)
						adj_q <= (adj_prod[48:28] > 21'h10000) ? 17'h10000 : adj_prod[44:28];
					else
						adj_q <= '0;
					state_q <= B_MIX;
				end
				B_MIX: begin
					for (int i = 0; i < 3; i++)
						mix_q[i] <= 23'(24'(17'h10000 - adj_q) * 24'(pal_q.steep[i])
							+ 24'(adj_q) * 24'(pal_q.flat[i]));
					state_q <= B_PROD;
				end
				B_PROD: begin
					for (int i = 0; i < 3; i++)
						prod_q[i] <= 40'(mix_q[i]) * 40'(f_q);
					state_q <= B_SCALE;
				end
				B_SCALE: begin
					if (!tri_q) begin
						c1_q    <= scaled;
						tri_q   <= 1'b1;
						state_q <= B_SQ;
					end else begin
						c2_q    <= scaled;
						k_q     <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_ch.ready) begin
						k_q <= k_q + 1'b1;
						if (k_q == 3'd5)
							state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last_of_quad) |=> !out_ch.valid)
		else $error("vertex beat after end of quad");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == B_D1W))
		else $error("divider busy outside a wait state");

endmodule

### rtl/heightmap_terrain_mesh_shader.sv
// Channel  | Dir | Beat content
// in_ch    | in  | height (signed Q8.8), row-major samples
// out_ch   | out | x_coord, y_height, z_coord, red, green, blue, last_of_quad
// cfg      | in  | cfg_we, cfg_index, cfg_wdata: grid_width (0), colour_scheme (1)
//
// A sample passes through the front end's IDLE, READ and PUSH states, and also WEND at a row end.
// A closed quad is computed in the back end and then sent as six output beats; the back end
// uses the 49-step restoring divider, once per triangle, and the 17-step square root.
// A two-entry quad queue lets the front end keep taking samples while the back end works.
// Reset is asynchronous; the line buffer needs no clearing pass.
// Output stalls hold the current vertex; beyond the front end's own cycles, input stalls
// only when the queue is full.
module heightmap_terrain_mesh_shader #(
	parameter int MAX_WIDTH   = hmt_pkg::MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = hmt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hmt_pkg::GW_W-1:0]      cfg_wdata,
	hmt_height_if.sink                    in_ch,
	hmt_vertex_if.source                  out_ch
);
	import hmt_pkg::*;

	logic [GW_W-1:0] grid_width_q;
	logic            colour_scheme_q;
	quad_t           fq_in, fq_out;
	logic            fq_push, fq_full, fq_pop, fq_empty, back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= GW_W'(2);
			colour_scheme_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH)
				grid_width_q <= cfg_wdata;
			else if (cfg_index == REG_COLOUR_SCHEME)
				colour_scheme_q <= cfg_wdata[0];
		end
	end

	hmt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.grid_width (grid_width_q),
		.in_ch      (in_ch),
		.quad       (fq_in),
		.quad_valid (fq_push),
		.quad_ready (!fq_full)
	);

	hmt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push && !fq_full),
		.push_data (fq_in),
		.full      (fq_full),
		.pop       (fq_pop),
		.pop_data  (fq_out),
		.empty     (fq_empty)
	);

	assign fq_pop = !fq_empty && back_ready;

	hmt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.colour_scheme (colour_scheme_q),
		.quad          (fq_out),
		.quad_valid    (!fq_empty),
		.quad_ready    (back_ready),
		.out_ch        (out_ch)
	);

endmodule
